/* src/dsss_pkg.sv */
`timescale 1ns / 1ps

package dsss_pkg;

	typedef logic [7:0] pattern_t;

	// Item operation codes.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Configuration register indexes.
	localparam logic REG_TICKS_PER_DIGIT = 1'b0;
	localparam logic REG_FRAMES_PER_SHOW = 1'b1;

	localparam logic [15:0] VALUE_LIMIT      = 16'd9999;
	localparam pattern_t    PATTERN_OVERFLOW = 8'b10000000;
	localparam pattern_t    DOT_MASK         = 8'b00000001;

	// Only the low four decimal places can be nonzero for values up to the limit.
	localparam int DEC_POSITIONS = 4;
	localparam int VAL_W         = 14;
	localparam int FRAC_W        = 27;
	localparam int RECIP_W       = 24;
	localparam int PROD_W        = VAL_W + RECIP_W;
	localparam int FRAC_ONE      = 2 ** FRAC_W;

	// Rounded-up reciprocals of 10, 100, 1000 and 10000, scaled by 2^FRAC_W.
	localparam logic [RECIP_W-1:0] DEC_RECIP [DEC_POSITIONS] = '{
		RECIP_W'((FRAC_ONE + 9) / 10),
		RECIP_W'((FRAC_ONE + 99) / 100),
		RECIP_W'((FRAC_ONE + 999) / 1000),
		RECIP_W'((FRAC_ONE + 9999) / 10000)
	};

	typedef struct packed {
		logic [7:0] ticks_per_digit;
		logic [7:0] frames_per_show;
	} cfg_t;

	typedef struct packed {
		pattern_t   segments;
		logic [3:0] digit_enable;
		logic       showing;
	} res_t;

	function automatic pattern_t seg_of(input logic [3:0] d);
		pattern_t p;
		case (d)
			4'd0: p = 8'b11111100;
			4'd1: p = 8'b01100000;
			4'd2: p = 8'b11011010;
			4'd3: p = 8'b11110010;
			4'd4: p = 8'b01100110;
			4'd5: p = 8'b10110110;
			4'd6: p = 8'b10111110;
			4'd7: p = 8'b11100000;
			4'd8: p = 8'b11111110;
			4'd9: p = 8'b11110110;
			default: p = 8'b00000000;
		endcase
		return p;
	endfunction

endpackage

/* src/dsss_digit_split.sv */
`timescale 1ns / 1ps

module dsss_digit_split #(
	parameter int DIGITS = 4
) (
	input  logic [15:0]                          value,
	input  logic [2:0]                           dot_digit,
	output dsss_pkg::pattern_t [DIGITS-1:0]      patterns
);
	import dsss_pkg::*;

	logic             overflow;
	logic [VAL_W-1:0] v;
	logic [3:0]       dec [DEC_POSITIONS];

	assign overflow = value > VALUE_LIMIT;
	assign v        = value[VAL_W-1:0];

	// Each decimal place is read from the fraction of v / 10^(k+1): the
	// fraction times ten, floored, is the digit. The reciprocal precision
	// keeps this exact for every value up to the limit.
	for (genvar k = 0; k < DEC_POSITIONS; k++) begin : g_dec
		logic [PROD_W-1:0] prod;
		logic [FRAC_W+3:0] times10;

		assign prod    = PROD_W'(v) * PROD_W'(DEC_RECIP[k]);
		assign times10 = {1'b0, prod[FRAC_W-1:0], 3'b000}
			+ {3'b000, prod[FRAC_W-1:0], 1'b0};
		assign dec[k]  = times10[FRAC_W+3:FRAC_W];
	end

	// Digit i counts from the left; its decimal place counts from the right.
	for (genvar i = 0; i < DIGITS; i++) begin : g_pat
		localparam int PLACE = DIGITS - 1 - i;
		pattern_t base;
		logic     dot_here;

		if (PLACE < DEC_POSITIONS) begin : g_num
			assign base = overflow ? PATTERN_OVERFLOW : seg_of(dec[PLACE]);
		end else begin : g_zero
			assign base = overflow ? PATTERN_OVERFLOW : seg_of(4'd0);
		end

		assign dot_here    = {1'b0, dot_digit} == 4'(i + 1);
		assign patterns[i] = dot_here ? (base | DOT_MASK) : base;
	end

endmodule

/* src/dsss_scan.sv */
`timescale 1ns / 1ps

module dsss_scan #(
	parameter int DIGITS = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 step,
	input  logic                                 op,
	input  dsss_pkg::pattern_t [DIGITS-1:0]      new_patterns,
	input  dsss_pkg::cfg_t                       cfg,
	output dsss_pkg::res_t                       result
);
	import dsss_pkg::*;

	localparam int SCAN_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	pattern_t [DIGITS-1:0] patterns_q;
	logic [SCAN_W-1:0]     scan_q;
	logic [7:0]            hold_q;
	logic [7:0]            frames_q;
	logic                  active_q;

	pattern_t [DIGITS-1:0] patterns_d;
	logic [SCAN_W-1:0]     scan_d;
	logic [7:0]            hold_d;
	logic [7:0]            frames_d;
	logic                  active_d;

	logic [7:0] hold_inc;
	logic [7:0] limit;
	logic [7:0] frames_dec;
	logic [3:0] enable;

	assign hold_inc   = hold_q + 8'd1;
	assign limit      = (cfg.ticks_per_digit == 8'd0) ? 8'd1 : cfg.ticks_per_digit;
	assign frames_dec = (frames_q != 8'd0) ? (frames_q - 8'd1) : 8'd0;

	always_comb begin
		enable = 4'b0000;
		for (int j = 0; j < 4; j++) begin
			if (j < DIGITS) begin
				enable[j] = scan_q == SCAN_W'(j);
			end
		end
	end

	// Every pattern written by a load is nonzero, so while a show runs the
	// current digit is never blank and no digit has to be passed over.
	always_comb begin
		patterns_d = patterns_q;
		scan_d     = scan_q;
		hold_d     = hold_q;
		frames_d   = frames_q;
		active_d   = active_q;
		result     = '0;
		if (op == OP_LOAD) begin
			patterns_d     = new_patterns;
			scan_d         = '0;
			hold_d         = 8'd0;
			frames_d       = cfg.frames_per_show;
			active_d       = cfg.frames_per_show != 8'd0;
			result.showing = cfg.frames_per_show != 8'd0;
		end else if (active_q) begin
			result.segments     = patterns_q[scan_q];
			result.digit_enable = enable;
			result.showing      = 1'b1;
			if (hold_inc >= limit) begin
				hold_d = 8'd0;
				if (scan_q == SCAN_W'(DIGITS - 1)) begin
					scan_d   = '0;
					frames_d = frames_dec;
					if (frames_dec == 8'd0) begin
						active_d = 1'b0;
					end
				end else begin
					scan_d = scan_q + SCAN_W'(1);
				end
			end else begin
				hold_d = hold_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			patterns_q <= '0;
			scan_q     <= '0;
			hold_q     <= 8'd0;
			frames_q   <= 8'd0;
			active_q   <= 1'b0;
		end else if (step) begin
			patterns_q <= patterns_d;
			scan_q     <= scan_d;
			hold_q     <= hold_d;
			frames_q   <= frames_d;
			active_q   <= active_d;
		end
	end

	a_active_has_frames: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> frames_q != 8'd0)
		else $error("show active with no frames left");

	a_active_digit_lit: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> patterns_q[scan_q] != '0)
		else $error("show active on a blank digit");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(scan_q) < DIGITS)
		else $error("scan digit beyond the last digit");

	a_hold_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q != 8'hFF)
		else $error("hold count reached its maximum");

	a_tick_idle_dark: assert property (@(posedge clk) disable iff (!arst_n)
		step && op == OP_TICK && !active_q |-> result == '0)
		else $error("idle tick drove the display");

endmodule

/* src/decimal_seven_segment_scanner.sv */
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Payload
// in       receive    in_valid / in_stall   op, value, dot_digit
// out      send       out_valid / out_stall segments, digit_enable, showing
// cfg      receive    cfg_valid / cfg_ready cfg_index, cfg_data
//
// The input register takes an item at its transfer edge, and the digit split or
// scan step fills the result register from it when the item advances, so the result
// passes through both registers. One item per cycle while the result is not stalled.
// The longest path is the reciprocal multiply of the decimal split on a load.
// Reset clears the scan state and the stored patterns and sets both configuration registers to one.
// A stalled result holds the input register; in_stall rises only then.

module decimal_seven_segment_scanner #(
	parameter int DIGITS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	input  logic [15:0]         value,
	input  logic [2:0]          dot_digit,
	output logic                out_valid,
	input  logic                out_stall,
	output dsss_pkg::pattern_t  segments,
	output logic [3:0]          digit_enable,
	output logic                showing,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_data
);
	import dsss_pkg::*;

	logic        valid_s1;
	logic        op_s1;
	logic [15:0] value_s1;
	logic [2:0]  dot_s1;

	cfg_t                  cfg_q;
	pattern_t [DIGITS-1:0] new_patterns;
	res_t                  result;
	logic                  advance;
	logic                  take_in;

	assign advance   = valid_s1 && (!out_valid || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign take_in   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_digit <= 8'd1;
			cfg_q.frames_per_show <= 8'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TICKS_PER_DIGIT: cfg_q.ticks_per_digit <= cfg_data;
				REG_FRAMES_PER_SHOW: cfg_q.frames_per_show <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			op_s1    <= op;
			value_s1 <= value;
			dot_s1   <= dot_digit;
		end
	end

	dsss_digit_split #(
		.DIGITS(DIGITS)
	) u_split (
		.value     (value_s1),
		.dot_digit (dot_s1),
		.patterns  (new_patterns)
	);

	dsss_scan #(
		.DIGITS(DIGITS)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.op           (op_s1),
		.new_patterns (new_patterns),
		.cfg          (cfg_q),
		.result       (result)
	);

	// The result register takes a new transfer whenever it is empty or drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || !out_stall) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			segments     <= result.segments;
			digit_enable <= result.digit_enable;
			showing      <= result.showing;
		end
	end

endmodule

/* test/decimal_seven_segment_scanner_tb.sv */
`timescale 1ns / 1ps

module decimal_seven_segment_scanner_tb;
	import dsss_pkg::*;

	localparam int NUM_DIRECTED = 26;
	localparam int NUM_PHASES   = 9;
	localparam int PHASE_ITEMS  = 205;

	localparam pattern_t DIGIT_SEGS [10] = '{
		8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6
	};

	// Register settings per phase, extremes included.
	localparam logic [7:0] PHASE_TICKS  [NUM_PHASES] = '{1, 0, 3, 255, 2, 1, 255, 0, 7};
	localparam logic [7:0] PHASE_FRAMES [NUM_PHASES] = '{1, 2, 0, 255, 3, 255, 1, 0, 4};

	typedef struct {
		logic       op;
		logic [15:0] value;
		logic [2:0]  dot;
		bit          fixed;
		res_t        res;
	} script_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        op;
	logic [15:0] value;
	logic [2:0]  dot_digit;
	logic        out_valid;
	logic        out_stall;
	pattern_t    segments;
	logic [3:0]  digit_enable;
	logic        showing;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [7:0]  cfg_data;

	// Sideband that travels with the payload: a fixed expectation for directed rows.
	bit   fixed_tag;
	res_t fixed_res;

	// Shadow of the display state.
	cfg_t       shadow_cfg;
	pattern_t   shadow_pats [4];
	logic [1:0] shadow_scan;
	logic [7:0] shadow_hold;
	logic [7:0] shadow_frames;
	bit         shadow_active;

	res_t        pending_results [$];
	script_row_t script [NUM_DIRECTED];

	int mismatches;
	int loads_sent;
	int ticks_sent;
	int results_checked;
	int reg_writes;
	int idle_pct;
	int stall_pct;

	decimal_seven_segment_scanner #(.DIGITS(4)) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.value        (value),
		.dot_digit    (dot_digit),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.segments     (segments),
		.digit_enable (digit_enable),
		.showing      (showing),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic void next_digit();
		shadow_hold = 8'd0;
		if (shadow_scan == 2'd3) begin
			shadow_scan = 2'd0;
			if (shadow_frames > 0)
				shadow_frames = shadow_frames - 8'd1;
			if (shadow_frames == 0)
				shadow_active = 1'b0;
		end else begin
			shadow_scan = shadow_scan + 2'd1;
		end
	endfunction

	function automatic res_t predict_display(input logic o, input logic [15:0] v,
						 input logic [2:0] d);
		res_t r;
		int   num;
		int   tries;
		logic [7:0] limit;
		r = '0;
		if (o == OP_LOAD) begin
			num = v;
			for (int i = 3; i >= 0; i--) begin
				if (v > VALUE_LIMIT) begin
					shadow_pats[i] = PATTERN_OVERFLOW;
				end else begin
					shadow_pats[i] = DIGIT_SEGS[num % 10];
					num = num / 10;
				end
			end
			if (d >= 3'd1 && d <= 3'd4)
				shadow_pats[d - 3'd1] = shadow_pats[d - 3'd1] | DOT_MASK;
			shadow_scan   = 2'd0;
			shadow_hold   = 8'd0;
			shadow_frames = shadow_cfg.frames_per_show;
			shadow_active = (shadow_frames != 0);
			r.showing     = shadow_active;
			return r;
		end
		if (!shadow_active)
			return r;
		// Blank digits are passed over without spending a tick.
		for (tries = 0; tries < 4 && shadow_active; tries++) begin
			if (shadow_pats[shadow_scan] != 0)
				break;
			next_digit();
		end
		if (!shadow_active || shadow_pats[shadow_scan] == 0) begin
			r.showing = shadow_active;
			return r;
		end
		r.segments     = shadow_pats[shadow_scan];
		r.digit_enable = 4'b0001 << shadow_scan;
		r.showing      = 1'b1;
		limit = (shadow_cfg.ticks_per_digit == 0) ? 8'd1 : shadow_cfg.ticks_per_digit;
		shadow_hold = shadow_hold + 8'd1;
		if (shadow_hold >= limit)
			next_digit();
		return r;
	endfunction

	// Record the expectation for every accepted item.
	always @(posedge clk) begin
		res_t r;
		if (arst_n && in_valid && !in_stall) begin
			r = predict_display(op, value, dot_digit);
			if (fixed_tag)
				r = fixed_res;
			pending_results.push_back(r);
			if (op == OP_LOAD)
				loads_sent++;
			else
				ticks_sent++;
		end
	end

	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			reg_writes++;
			case (cfg_index)
				REG_TICKS_PER_DIGIT: shadow_cfg.ticks_per_digit = cfg_data;
				REG_FRAMES_PER_SHOW: shadow_cfg.frames_per_show = cfg_data;
			endcase
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result: expected none, actual %h/%b/%b",
					 $time, segments, digit_enable, showing);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (segments !== want.segments) begin
					mismatches++;
					$display("%0t: segments expected %h actual %h",
						 $time, want.segments, segments);
				end
				if (digit_enable !== want.digit_enable) begin
					mismatches++;
					$display("%0t: digit_enable expected %b actual %b",
						 $time, want.digit_enable, digit_enable);
				end
				if (showing !== want.showing) begin
					mismatches++;
					$display("%0t: showing expected %b actual %b",
						 $time, want.showing, showing);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	task automatic push_item(input logic o, input logic [15:0] v, input logic [2:0] d,
				 input bit fixed, input res_t res);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		op        <= o;
		value     <= v;
		dot_digit <= d;
		fixed_tag <= fixed;
		fixed_res <= res;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic set_registers(input logic [7:0] ticks, input logic [7:0] frames);
		wait_for_results();
		repeat (3) @(posedge clk);
		write_reg(REG_TICKS_PER_DIGIT, ticks);
		write_reg(REG_FRAMES_PER_SHOW, frames);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] pick_value();
		logic [15:0] v;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: v = 16'd0;
					1: v = VALUE_LIMIT;
					2: v = VALUE_LIMIT + 16'd1;
					default: v = 16'hFFFF;
				endcase
			end
			1, 2: v = 16'($urandom_range(0, 65535));
			default: v = 16'($urandom_range(0, 9999));
		endcase
		return v;
	endfunction

	initial begin
		script = '{
			// Idle tick after reset, then one full frame of zeros.
			'{OP_TICK, 16'd0,     3'd0, 1'b1, {8'h00, 4'b0000, 1'b0}},
			'{OP_LOAD, 16'd0,     3'd0, 1'b1, {8'h00, 4'b0000, 1'b1}},
			'{OP_TICK, 16'd0,     3'd0, 1'b1, {8'hFC, 4'b0001, 1'b1}},
			'{OP_TICK, 16'd0,     3'd0, 1'b1, {8'hFC, 4'b0010, 1'b1}},
			'{OP_TICK, 16'd0,     3'd0, 1'b1, {8'hFC, 4'b0100, 1'b1}},
			'{OP_TICK, 16'd0,     3'd0, 1'b1, {8'hFC, 4'b1000, 1'b1}},
			'{OP_TICK, 16'd0,     3'd0, 1'b1, {8'h00, 4'b0000, 1'b0}},
			'{OP_LOAD, 16'd9999,  3'd4, 1'b1, {8'h00, 4'b0000, 1'b1}},
			'{OP_TICK, 16'd0,     3'd0, 1'b1, {8'hF6, 4'b0001, 1'b1}},
			'{OP_TICK, 16'd0,     3'd0, 1'b0, '0},
			// A load in the middle of a show restarts it.
			'{OP_LOAD, 16'd1234,  3'd2, 1'b0, '0},
			'{OP_TICK, 16'hFFFF,  3'd7, 1'b0, '0},
			'{OP_TICK, 16'd0,     3'd0, 1'b0, '0},
			'{OP_LOAD, 16'd10000, 3'd1, 1'b1, {8'h00, 4'b0000, 1'b1}},
			'{OP_TICK, 16'd0,     3'd0, 1'b1, {8'h81, 4'b0001, 1'b1}},
			'{OP_TICK, 16'd0,     3'd0, 1'b1, {8'h80, 4'b0010, 1'b1}},
			'{OP_LOAD, 16'hFFFF,  3'd7, 1'b0, '0},
			'{OP_TICK, 16'd0,     3'd0, 1'b0, '0},
			'{OP_TICK, 16'd0,     3'd0, 1'b0, '0},
			'{OP_TICK, 16'd0,     3'd0, 1'b0, '0},
			'{OP_TICK, 16'd0,     3'd0, 1'b0, '0},
			'{OP_LOAD, 16'd5678,  3'd5, 1'b0, '0},
			'{OP_TICK, 16'd0,     3'd0, 1'b0, '0},
			'{OP_TICK, 16'd0,     3'd0, 1'b0, '0},
			'{OP_LOAD, 16'd9990,  3'd3, 1'b0, '0},
			'{OP_TICK, 16'd0,     3'd0, 1'b0, '0}
		};

		shadow_cfg.ticks_per_digit = 8'd1;
		shadow_cfg.frames_per_show = 8'd1;
		for (int i = 0; i < 4; i++)
			shadow_pats[i] = '0;
		shadow_scan     = 2'd0;
		shadow_hold     = 8'd0;
		shadow_frames   = 8'd0;
		shadow_active   = 1'b0;
		mismatches      = 0;
		loads_sent      = 0;
		ticks_sent      = 0;
		results_checked = 0;
		reg_writes      = 0;
		idle_pct        = 13;
		stall_pct       = 13;

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		op        = OP_TICK;
		value     = '0;
		dot_digit = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_TICKS_PER_DIGIT;
		cfg_data  = '0;
		fixed_tag = 1'b0;
		fixed_res = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			push_item(script[i].op, script[i].value, script[i].dot,
				  script[i].fixed, script[i].res);

		for (int p = 0; p < NUM_PHASES; p++) begin
			set_registers(PHASE_TICKS[p], PHASE_FRAMES[p]);
			// One phase runs with both sides streaming back to back.
			idle_pct  = (p == 4) ? 0 : 13;
			stall_pct = (p == 4) ? 0 : 13;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 2 && n == PHASE_ITEMS / 2)
					wait_for_results();
				// Mostly ticks with an occasional load, so short shows run to completion.
				if ($urandom_range(0, 99) < 10)
					push_item(OP_LOAD, pick_value(), 3'($urandom_range(0, 7)), 1'b0, '0);
				else
					push_item(OP_TICK, 16'($urandom_range(0, 65535)),
						  3'($urandom_range(0, 7)), 1'b0, '0);
			end
		end

		wait_for_results();
		repeat (8) @(posedge clk);
		$display("Covered %0d loads and %0d ticks over %0d register writes;",
			 loads_sent, ticks_sent, reg_writes);
		$display("%0d results compared against the shadow display state.", results_checked);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
